/* sv/eso_pkg.sv */
// types, codes and fixed widths shared by the encoder speed and odometry block
// no dependencies; imported by eso_ctrl, eso_datapath and the top level
`timescale 1ns / 1ps

package eso_pkg;

    // configuration port
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC = 1'b1;
    localparam logic [CFG_W-1:0] CPR_RESET  = 24'd85333;
    localparam logic [CFG_W-1:0] CIRC_RESET = 24'd204204;

    // word fields
    localparam int CMD_W      = 2;
    localparam int COUNT_IN_W = 32;
    localparam int TIME_W     = 63;
    localparam int RPM_W      = 32;
    localparam int DIST_W     = 40;
    localparam int TRAVEL_W   = 40;
    localparam int OUT_WHEELS = 2;

    // shared multiplier: one 16-bit digit of the b operand per step
    localparam int MUL_B_W   = 64;
    localparam int MUL_DIG   = 16;
    localparam int MUL_STEPS = MUL_B_W / MUL_DIG;
    localparam logic [MUL_B_W-1:0] SPEED_SCALE = 64'd3932160000000;

    // shared restoring divider
    localparam int DEN_W     = CFG_W + TIME_W;
    localparam int SPD_QBITS = RPM_W - 1;
    localparam int DST_QBITS = DIST_W - 1;
    localparam int DIV_W     = DEN_W + SPD_QBITS;
    localparam int QUO_W     = DST_QBITS + 1;
    localparam int STEP_W    = $clog2(QUO_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE  = 2'd0,
        CMD_CLEAR_L = 2'd1,
        CMD_CLEAR_R = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_DEN_LOAD,
        DP_SPD_LOAD,
        DP_DST_LOAD,
        DP_MUL_STEP,
        DP_DEN_SAVE,
        DP_SPD_DIVLD,
        DP_DST_DIVLD,
        DP_DIV_STEP,
        DP_SPD_SAVE,
        DP_DST_SAVE,
        DP_COMMIT,
        DP_CLEAR,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   wheel;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos;
    } t_dp_status;

endpackage

/* sv/eso_ctrl.sv */
// sequencer for the encoder speed and odometry block
// depends on eso_pkg; drives eso_datapath one operation per cycle while working, holding while the output stalls
`timescale 1ns / 1ps

module eso_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  eso_pkg::t_dp_status i_status,
    output eso_pkg::t_dp_cmd    o_cmd
);
    import eso_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_DEN_LD,
        S_DEN_MUL,
        S_DEN_SV,
        S_SPD_LD,
        S_SPD_MUL,
        S_SPD_DVL,
        S_SPD_DIV,
        S_SPD_SV,
        S_COMMIT,
        S_CLEAR,
        S_DST_LD,
        S_DST_MUL,
        S_DST_DVL,
        S_DST_DIV,
        S_DST_SV,
        S_RESULT,
        S_OUT
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic                r_wheel;
    logic                n_wheel;
    t_dp_op              n_op;
    t_dp_cmd             r_cmd;
    logic                r_in_stall;
    logic                r_out_valid;

    always_comb begin
        n_state = r_state;
        n_step  = '0;
        n_wheel = r_wheel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_wheel = 1'b0;
                unique case (i_status.cmd) inside
                    CMD_UPDATE: begin
                        n_state = i_status.pos ? S_DEN_LD : S_COMMIT;
                    end
                    CMD_CLEAR_L, CMD_CLEAR_R: begin
                        n_state = S_CLEAR;
                        n_wheel = (i_status.cmd == CMD_CLEAR_R);
                    end
                    default: begin
                        n_state = S_DST_LD;
                    end
                endcase
            end
            S_DEN_LD:  n_state = S_DEN_MUL;
            S_DEN_MUL: begin
                n_step = STEP_W'(r_step + 1'b1);
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = S_DEN_SV;
                end
            end
            S_DEN_SV:  n_state = S_SPD_LD;
            S_SPD_LD:  n_state = S_SPD_MUL;
            S_SPD_MUL: begin
                n_step = STEP_W'(r_step + 1'b1);
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = S_SPD_DVL;
                end
            end
            S_SPD_DVL: n_state = S_SPD_DIV;
            S_SPD_DIV: begin
                n_step = STEP_W'(r_step + 1'b1);
                if (r_step == STEP_W'(SPD_QBITS)) begin
                    n_state = S_SPD_SV;
                end
            end
            S_SPD_SV: begin
                if (!r_wheel) begin
                    n_wheel = 1'b1;
                    n_state = S_SPD_LD;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT, S_CLEAR: begin
                n_wheel = 1'b0;
                n_state = S_DST_LD;
            end
            S_DST_LD:  n_state = S_DST_MUL;
            S_DST_MUL: begin
                n_step = STEP_W'(r_step + 1'b1);
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = S_DST_DVL;
                end
            end
            S_DST_DVL: n_state = S_DST_DIV;
            S_DST_DIV: begin
                n_step = STEP_W'(r_step + 1'b1);
                if (r_step == STEP_W'(DST_QBITS)) begin
                    n_state = S_DST_SV;
                end
            end
            S_DST_SV: begin
                if (!r_wheel) begin
                    n_wheel = 1'b1;
                    n_state = S_DST_LD;
                end else begin
                    n_state = S_RESULT;
                end
            end
            // the output slot frees at this edge if the held word is taken
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_OUT;
                end
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath operation carried out while in the next state
    always_comb begin
        unique case (n_state)
            S_DEN_LD:               n_op = DP_DEN_LOAD;
            S_SPD_LD:               n_op = DP_SPD_LOAD;
            S_DST_LD:               n_op = DP_DST_LOAD;
            S_DEN_MUL, S_SPD_MUL,
            S_DST_MUL:              n_op = DP_MUL_STEP;
            S_DEN_SV:               n_op = DP_DEN_SAVE;
            S_SPD_DVL:              n_op = DP_SPD_DIVLD;
            S_DST_DVL:              n_op = DP_DST_DIVLD;
            S_SPD_DIV, S_DST_DIV:   n_op = DP_DIV_STEP;
            S_SPD_SV:               n_op = DP_SPD_SAVE;
            S_DST_SV:               n_op = DP_DST_SAVE;
            S_COMMIT:               n_op = DP_COMMIT;
            S_CLEAR:                n_op = DP_CLEAR;
            S_OUT:                  n_op = DP_RESULT;
            default:                n_op = DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_wheel     <= 1'b0;
            r_cmd       <= '{op: DP_NOP, wheel: 1'b0};
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_wheel    <= n_wheel;
            r_cmd      <= '{op: n_op, wheel: n_wheel};
            r_in_stall <= (n_state != S_IDLE);
            if (r_state == S_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = r_cmd;

endmodule

/* sv/eso_datapath.sv */
// datapath: wheel state, config registers, shared 16-bit digit multiplier,
// shared restoring divider and output word registers; depends on eso_pkg
`timescale 1ns / 1ps

module eso_datapath #(
    parameter int COUNT_WIDTH = 32,
    parameter int WHEELS      = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [eso_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [eso_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                  i_accept,
    input  logic [eso_pkg::CMD_W-1:0]             i_command,
    input  logic signed [eso_pkg::COUNT_IN_W-1:0] i_count_left,
    input  logic signed [eso_pkg::COUNT_IN_W-1:0] i_count_right,
    input  logic [eso_pkg::TIME_W-1:0]            i_time_us,
    input  eso_pkg::t_dp_cmd                      i_cmd,
    output eso_pkg::t_dp_status                   o_status,
    output logic signed [eso_pkg::RPM_W-1:0]      o_rpm_left_q8,
    output logic signed [eso_pkg::RPM_W-1:0]      o_rpm_right_q8,
    output logic signed [eso_pkg::DIST_W-1:0]     o_distance_left_um,
    output logic signed [eso_pkg::DIST_W-1:0]     o_distance_right_um
);
    import eso_pkg::*;

    localparam int ACT_WHEELS = (WHEELS < OUT_WHEELS) ? WHEELS : OUT_WHEELS;
    localparam int MAG_W      = (COUNT_WIDTH > TRAVEL_W) ? COUNT_WIDTH : TRAVEL_W;
    localparam int SUM_W      = MAG_W + 1;
    localparam int ACC_W      = MAG_W + MUL_B_W;

    logic [CFG_W-1:0]              r_cpr;
    logic [CFG_W-1:0]              r_circ;
    logic [TIME_W-1:0]             r_prev_time;
    logic [CMD_W-1:0]              r_cmd_code;
    logic signed [COUNT_WIDTH-1:0] r_cur [OUT_WHEELS];
    logic [TIME_W-1:0]             r_now;
    logic [MAG_W-1:0]              r_mul_a;
    logic [MUL_B_W-1:0]            r_mul_b;
    logic [ACC_W-1:0]              r_acc;
    logic [DEN_W-1:0]              r_den;
    logic [DIV_W-1:0]              r_rem;
    logic [DIV_W-1:0]              r_dsh;
    logic [QUO_W-1:0]              r_quo;
    logic                          r_num_zero;
    logic signed [DIST_W-1:0]      r_res_dist [OUT_WHEELS];
    logic signed [RPM_W-1:0]       r_out_rpm [OUT_WHEELS];
    logic signed [DIST_W-1:0]      r_out_dist [OUT_WHEELS];

    logic signed [COUNT_WIDTH-1:0] v_prev [OUT_WHEELS];
    logic signed [RPM_W-1:0]       v_speed [OUT_WHEELS];
    logic signed [TRAVEL_W-1:0]    v_travel [OUT_WHEELS];

    logic signed [COUNT_WIDTH-1:0] v_delta;
    logic [COUNT_WIDTH-1:0]        v_delta_mag;
    logic signed [TRAVEL_W-1:0]    v_trav_sel;
    logic [TRAVEL_W-1:0]           v_trav_mag;
    logic signed [SUM_W-1:0]       v_sum;
    logic signed [TRAVEL_W-1:0]    v_travel_new;
    logic [TIME_W-1:0]             v_dt;
    logic [MAG_W+MUL_DIG-1:0]      v_prod;
    logic                          v_ge;
    logic [SPD_QBITS:0]            v_spd_q;
    logic [DST_QBITS:0]            v_dst_q;
    logic signed [RPM_W-1:0]       v_speed_new;
    logic signed [DIST_W-1:0]      v_dist_new;

    // per-wheel state; wheels without storage read as zero
    for (genvar w = 0; w < OUT_WHEELS; w++) begin : g_wheel
        if (w < ACT_WHEELS) begin : g_store
            logic signed [COUNT_WIDTH-1:0] r_prev_count;
            logic signed [RPM_W-1:0]       r_speed;
            logic signed [TRAVEL_W-1:0]    r_travel;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_prev_count <= '0;
                    r_speed      <= '0;
                    r_travel     <= '0;
                end else begin
                    unique case (i_cmd.op)
                        DP_SPD_SAVE: begin
                            if (i_cmd.wheel == 1'(w)) begin
                                r_speed  <= v_speed_new;
                                r_travel <= v_travel_new;
                            end
                        end
                        DP_CLEAR: begin
                            if (i_cmd.wheel == 1'(w)) begin
                                r_prev_count <= '0;
                                r_travel     <= '0;
                            end
                        end
                        DP_COMMIT: r_prev_count <= r_cur[w];
                        default: ;
                    endcase
                end
            end

            assign v_prev[w]   = r_prev_count;
            assign v_speed[w]  = r_speed;
            assign v_travel[w] = r_travel;
        end else begin : g_none
            assign v_prev[w]   = '0;
            assign v_speed[w]  = '0;
            assign v_travel[w] = '0;
        end
    end

    always_comb begin
        // delta wraps at the count width
        v_delta     = r_cur[i_cmd.wheel] - v_prev[i_cmd.wheel];
        v_delta_mag = v_delta[COUNT_WIDTH-1] ? unsigned'(-v_delta) : unsigned'(v_delta);
        v_trav_sel  = v_travel[i_cmd.wheel];
        v_trav_mag  = v_trav_sel[TRAVEL_W-1] ? unsigned'(-v_trav_sel) : unsigned'(v_trav_sel);

        v_sum = SUM_W'(v_delta) + SUM_W'(v_trav_sel);
        if ((v_sum[SUM_W-1:TRAVEL_W-1] == '0) || (v_sum[SUM_W-1:TRAVEL_W-1] == '1)) begin
            v_travel_new = v_sum[TRAVEL_W-1:0];
        end else begin
            v_travel_new = {v_sum[SUM_W-1], {(TRAVEL_W-1){!v_sum[SUM_W-1]}}};
        end

        v_dt   = r_now - r_prev_time;
        v_prod = r_mul_a * r_mul_b[MUL_B_W-1 -: MUL_DIG];
        v_ge   = (r_rem >= r_dsh);

        // top quotient bit set means the quotient reached the cap
        v_spd_q = r_quo[SPD_QBITS:0];
        if (r_num_zero) begin
            v_speed_new = '0;
        end else if (v_spd_q[SPD_QBITS]) begin
            v_speed_new = v_delta[COUNT_WIDTH-1] ? {1'b1, {SPD_QBITS{1'b0}}}
                                                 : {1'b0, {SPD_QBITS{1'b1}}};
        end else begin
            v_speed_new = v_delta[COUNT_WIDTH-1] ? -signed'(v_spd_q) : signed'(v_spd_q);
        end

        v_dst_q = r_quo[DST_QBITS:0];
        if (r_num_zero) begin
            v_dist_new = '0;
        end else if (v_dst_q[DST_QBITS]) begin
            v_dist_new = v_trav_sel[TRAVEL_W-1] ? {1'b1, {DST_QBITS{1'b0}}}
                                                : {1'b0, {DST_QBITS{1'b1}}};
        end else begin
            v_dist_new = v_trav_sel[TRAVEL_W-1] ? -signed'(v_dst_q) : signed'(v_dst_q);
        end
    end

    // registers that reset clears or loads with the config defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr       <= CPR_RESET;
            r_circ      <= CIRC_RESET;
            r_prev_time <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CPR:  r_cpr  <= i_cfg_data;
                    CFG_CIRC: r_circ <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == DP_COMMIT) begin
                r_prev_time <= r_now;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd_code <= i_command;
            r_cur[0]   <= COUNT_WIDTH'(i_count_left);
            r_cur[1]   <= COUNT_WIDTH'(i_count_right);
            r_now      <= i_time_us;
        end
        unique case (i_cmd.op)
            DP_DEN_LOAD: begin
                r_mul_a <= MAG_W'(r_cpr);
                r_mul_b <= MUL_B_W'(v_dt);
                r_acc   <= '0;
            end
            DP_SPD_LOAD: begin
                r_mul_a <= MAG_W'(v_delta_mag);
                r_mul_b <= SPEED_SCALE;
                r_acc   <= '0;
            end
            DP_DST_LOAD: begin
                r_mul_a <= MAG_W'(v_trav_mag);
                r_mul_b <= MUL_B_W'({r_circ, 8'b0});
                r_acc   <= '0;
            end
            DP_MUL_STEP: begin
                r_acc   <= (r_acc << MUL_DIG) + ACC_W'(v_prod);
                r_mul_b <= r_mul_b << MUL_DIG;
            end
            DP_DEN_SAVE: r_den <= r_acc[DEN_W-1:0];
            DP_SPD_DIVLD: begin
                r_rem      <= DIV_W'(r_acc);
                r_dsh      <= DIV_W'(r_den) << SPD_QBITS;
                r_quo      <= '0;
                r_num_zero <= (r_acc == '0);
            end
            DP_DST_DIVLD: begin
                r_rem      <= DIV_W'(r_acc);
                r_dsh      <= DIV_W'(r_cpr) << DST_QBITS;
                r_quo      <= '0;
                r_num_zero <= (r_acc == '0);
            end
            DP_DIV_STEP: begin
                if (v_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quo <= {r_quo[QUO_W-2:0], v_ge};
                r_dsh <= r_dsh >> 1;
            end
            DP_DST_SAVE: r_res_dist[i_cmd.wheel] <= v_dist_new;
            DP_RESULT: begin
                r_out_rpm[0]  <= v_speed[0];
                r_out_rpm[1]  <= v_speed[1];
                r_out_dist[0] <= r_res_dist[0];
                r_out_dist[1] <= r_res_dist[1];
            end
            default: ;
        endcase
    end

    assign o_status = '{cmd: r_cmd_code, pos: (r_now > r_prev_time)};

    assign o_rpm_left_q8       = r_out_rpm[0];
    assign o_rpm_right_q8      = r_out_rpm[1];
    assign o_distance_left_um  = r_out_dist[0];
    assign o_distance_right_um = r_out_dist[1];

endmodule

/* sv/encoder_speed_odometry_top.sv */
// an update with positive elapsed time forms the denominator product, then both wheel
// speeds, then both distances; other commands form only the distances; no new word is
// taken until the last result is loaded; the work is done by the one-bit-per-cycle divider
// (32 steps per speed, 40 per distance, both wheels in turn) and 4-step multiplier
// reset: synchronous active low; clears wheel state, last time, handshake state and
// loads the config defaults, no clearing pass
`timescale 1ns / 1ps

module encoder_speed_odometry_top #(
    parameter int COUNT_WIDTH = 32,
    parameter int WHEELS      = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [eso_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [eso_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [eso_pkg::CMD_W-1:0]             i_command,
    input  logic signed [eso_pkg::COUNT_IN_W-1:0] i_count_left,
    input  logic signed [eso_pkg::COUNT_IN_W-1:0] i_count_right,
    input  logic [eso_pkg::TIME_W-1:0]            i_time_us,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [eso_pkg::RPM_W-1:0]      o_rpm_left_q8,
    output logic signed [eso_pkg::RPM_W-1:0]      o_rpm_right_q8,
    output logic signed [eso_pkg::DIST_W-1:0]     o_distance_left_um,
    output logic signed [eso_pkg::DIST_W-1:0]     o_distance_right_um
);
    import eso_pkg::*;

    t_dp_cmd    w_dp_cmd;
    t_dp_status w_dp_status;
    logic       w_accept;

    assign w_accept = i_in_valid && !o_in_stall;

    eso_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_dp_status),
        .o_cmd       (w_dp_cmd)
    );

    eso_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .WHEELS      (WHEELS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_accept            (w_accept),
        .i_command           (i_command),
        .i_count_left        (i_count_left),
        .i_count_right       (i_count_right),
        .i_time_us           (i_time_us),
        .i_cmd               (w_dp_cmd),
        .o_status            (w_dp_status),
        .o_rpm_left_q8       (o_rpm_left_q8),
        .o_rpm_right_q8      (o_rpm_right_q8),
        .o_distance_left_um  (o_distance_left_um),
        .o_distance_right_um (o_distance_right_um)
    );

    // input side closes right after a word is taken
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not closed after acceptance");

    // datapath only works while the input side is closed
    a_busy_when_working: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dp_cmd.op != DP_NOP) |-> o_in_stall)
        else $error("datapath operation while input open");

    // a result loads only into a free output slot and then shows
    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dp_cmd.op == DP_RESULT) |-> !o_out_valid ##1 o_out_valid)
        else $error("result loaded over a pending word");

    // a clear only follows a clear command
    a_clear_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dp_cmd.op == DP_CLEAR) |->
            (w_dp_status.cmd == CMD_CLEAR_L || w_dp_status.cmd == CMD_CLEAR_R))
        else $error("clear without clear command");

endmodule
